@@ hw/rtl/gbfp_pkg.sv @@
// Package for the binary frame parser: parse phases, state and result structs.
// No dependencies; used by gbfp_step and gnss_binary_frame_parser_unit.
package gbfp_pkg;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SYNC_FIRST    = 2'd0,
    REG_SYNC_SECOND   = 2'd1,
    REG_PAYLOAD_LIMIT = 2'd2
  } cfg_reg_e;

  localparam logic [7:0]  SyncFirstReset    = 8'd181;
  localparam logic [7:0]  SyncSecondReset   = 8'd98;
  localparam logic [15:0] PayloadLimitReset = 16'd256;

  typedef enum logic [8:0] {
    PH_SYNC1   = 9'b000000001,
    PH_SYNC2   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CHECK_A = 9'b010000000,
    PH_CHECK_B = 9'b100000000
  } phase_e;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  check_a;
    logic [7:0]  check_b;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    logic [15:0] byte_position;
  } parse_state_t;

  typedef struct packed {
    logic        frame_ok;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic        payload_valid;
    logic [15:0] payload_index;
    logic [7:0]  payload_byte;
  } result_t;

endpackage

@@ hw/rtl/gbfp_step.sv @@
// Combinational update of the frame parser for one received word.
// Depends on gbfp_pkg for the phase, state, config and result types.
module gbfp_step (
  input  gbfp_pkg::parse_state_t state_i,
  input  gbfp_pkg::cfg_t         cfg_i,
  input  logic [7:0]             rx_byte_i,
  output gbfp_pkg::parse_state_t state_o,
  output gbfp_pkg::result_t      result_o
);
  import gbfp_pkg::*;

  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] len_full;
  logic [15:0] pos_next;

  // Fletcher-8 running sums with this word folded in
  assign sum_a    = state_i.check_a + rx_byte_i;
  assign sum_b    = state_i.check_b + sum_a;
  assign len_full = state_i.frame_length | {rx_byte_i, 8'h00};
  assign pos_next = state_i.byte_position + 16'd1;

  always_comb begin
    parse_state_t nxt;
    logic         ok;
    logic         pvalid;
    nxt    = state_i;
    ok     = 1'b0;
    pvalid = 1'b0;
    unique case (state_i.phase)
      PH_SYNC2: begin
        nxt.phase   = (rx_byte_i == cfg_i.sync_second) ? PH_CLASS : PH_SYNC1;
        nxt.check_a = 8'h00;
        nxt.check_b = 8'h00;
      end
      PH_CLASS: begin
        nxt.frame_class = rx_byte_i;
        nxt.check_a     = sum_a;
        nxt.check_b     = sum_b;
        nxt.phase       = PH_ID;
      end
      PH_ID: begin
        nxt.frame_id = rx_byte_i;
        nxt.check_a  = sum_a;
        nxt.check_b  = sum_b;
        nxt.phase    = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        nxt.frame_length = {8'h00, rx_byte_i};
        nxt.check_a      = sum_a;
        nxt.check_b      = sum_b;
        nxt.phase        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        nxt.frame_length  = len_full;
        nxt.check_a       = sum_a;
        nxt.check_b       = sum_b;
        nxt.byte_position = 16'd0;
        if (len_full > cfg_i.payload_limit) begin
          nxt.phase = PH_SYNC1;
        end else if (len_full != 16'd0) begin
          nxt.phase = PH_PAYLOAD;
        end else begin
          nxt.phase = PH_CHECK_A;
        end
      end
      PH_PAYLOAD: begin
        pvalid            = 1'b1;
        nxt.check_a       = sum_a;
        nxt.check_b       = sum_b;
        nxt.byte_position = pos_next;
        if (pos_next >= state_i.frame_length) begin
          nxt.phase = PH_CHECK_A;
        end
      end
      PH_CHECK_A: begin
        nxt.phase = (rx_byte_i == state_i.check_a) ? PH_CHECK_B : PH_SYNC1;
      end
      PH_CHECK_B: begin
        nxt.phase = PH_SYNC1;
        ok        = (rx_byte_i == state_i.check_b);
      end
      default: begin
        nxt.phase = (rx_byte_i == cfg_i.sync_first) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase

    state_o                 = nxt;
    result_o.frame_ok       = ok;
    result_o.msg_class      = nxt.frame_class;
    result_o.msg_id         = nxt.frame_id;
    result_o.payload_length = nxt.frame_length;
    result_o.payload_valid  = pvalid;
    result_o.payload_index  = pvalid ? state_i.byte_position : 16'd0;
    result_o.payload_byte   = pvalid ? rx_byte_i : 8'h00;
  end

endmodule

@@ hw/rtl/gnss_binary_frame_parser_unit.sv @@
// Binary frame parser with Fletcher-8 check: top level with handshake,
// configuration registers and output register. Depends on gbfp_pkg, gbfp_step.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, rx_byte_i) takes one stream word
//   per accepted handshake. Each accepted word yields exactly one result word
//   on the output channel (out_valid_o/out_ready_i): frame_ok, the header
//   fields of the current frame, and the payload byte with its index when the
//   word was payload.
//   The result is registered and appears the cycle after acceptance.
//   Throughput is one word per cycle while the receiver takes results; the parser state and the result
//   register update in a single pass through gbfp_step.
//   When the receiver stalls, the result is held in the output register and
//   in_ready_o drops until it is taken; a word is accepted in the same cycle
//   the held result leaves.
//   Configuration (cfg_we_i/cfg_idx_i/cfg_data_i) writes sync_first,
//   sync_second and payload_limit; write only while the block is idle.
//   Index 3 is ignored.
//   Reset clears the parser to sync hunting with zero sums and header
//   fields, loads the default registers, and empties the output register.
module gnss_binary_frame_parser_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gbfp_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [gbfp_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              frame_ok_o,
  output logic [7:0]                        msg_class_o,
  output logic [7:0]                        msg_id_o,
  output logic [15:0]                       payload_length_o,
  output logic                              payload_valid_o,
  output logic [15:0]                       payload_index_o,
  output logic [7:0]                        payload_byte_o
);
  import gbfp_pkg::*;

  cfg_t         cfg_q;
  parse_state_t state_q;
  parse_state_t state_d;
  result_t      result_d;
  result_t      result_q;
  logic         out_valid_q;
  logic         accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first    <= SyncFirstReset;
      cfg_q.sync_second   <= SyncSecondReset;
      cfg_q.payload_limit <= PayloadLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SYNC_FIRST:    cfg_q.sync_first    <= cfg_data_i[7:0];
        REG_SYNC_SECOND:   cfg_q.sync_second   <= cfg_data_i[7:0];
        REG_PAYLOAD_LIMIT: cfg_q.payload_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gbfp_step u_step (
    .state_i   (state_q),
    .cfg_i     (cfg_q),
    .rx_byte_i (rx_byte_i),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= PH_SYNC1;
      state_q.check_a       <= 8'h00;
      state_q.check_b       <= 8'h00;
      state_q.frame_class   <= 8'h00;
      state_q.frame_id      <= 8'h00;
      state_q.frame_length  <= 16'h0000;
      state_q.byte_position <= 16'h0000;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // whole result word, no reset; hold while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (accept) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_ok_o       = result_q.frame_ok;
  assign msg_class_o      = result_q.msg_class;
  assign msg_id_o         = result_q.msg_id;
  assign payload_length_o = result_q.payload_length;
  assign payload_valid_o  = result_q.payload_valid;
  assign payload_index_o  = result_q.payload_index;
  assign payload_byte_o   = result_q.payload_byte;

endmodule

@@ hw/rtl/gbfp_checker.sv @@
// Port-level checker for gnss_binary_frame_parser_unit, bound to the top level.
// Depends only on the top level's ports.
module gbfp_port_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        frame_ok_o,
  input logic [15:0] payload_length_o,
  input logic        payload_valid_o,
  input logic [15:0] payload_index_o,
  input logic [7:0]  payload_byte_o
);

  // a stalled result word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(payload_index_o)
      && $stable(payload_byte_o) && $stable(frame_ok_o))
    else $error("stalled result changed");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // each accepted word shows up as a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted word produced no result");

  // frame end and payload are exclusive; payload index stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && payload_valid_o |-> !frame_ok_o && payload_index_o < payload_length_o)
    else $error("payload word inconsistent with frame");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !payload_valid_o |-> payload_index_o == 16'd0 && payload_byte_o == 8'h00)
    else $error("non-payload word carries payload data");

endmodule

bind gnss_binary_frame_parser_unit gbfp_port_checker u_gbfp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .frame_ok_o       (frame_ok_o),
  .payload_length_o (payload_length_o),
  .payload_valid_o  (payload_valid_o),
  .payload_index_o  (payload_index_o),
  .payload_byte_o   (payload_byte_o)
);

@@ verif/gbfp_checker.sv @@
// Checker for the binary frame parser: tracks the frame state from accepted stream
// words and register writes, and compares every result word field by field.
// Depends on gbfp_pkg; instantiated beside the parser by the testbench top.
module gbfp_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [gbfp_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [gbfp_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  gbfp_pkg::result_t                 result_i,
  output int                                errors_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gbfp_pkg::*;

  logic [7:0]  sync1_q;
  logic [7:0]  sync2_q;
  logic [15:0] limit_q;

  phase_e      phase_q;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [7:0]  class_q;
  logic [7:0]  id_q;
  logic [15:0] length_q;
  logic [15:0] position_q;

  result_t     expected_words[$];
  int          mismatches;
  int          pending;

  assign errors_o  = mismatches;
  assign pending_o = pending;

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at %0t in %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  task automatic add_to_sums(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endtask

  // Advance the frame state by one stream byte and build the result word.
  task automatic parse_byte(input logic [7:0] b, output result_t word);
    word = '0;
    case (phase_q)
      PH_SYNC2: begin
        phase_q = (b == sync2_q) ? PH_CLASS : PH_SYNC1;
        sum_a = '0;
        sum_b = '0;
      end
      PH_CLASS: begin
        class_q = b;
        add_to_sums(b);
        phase_q = PH_ID;
      end
      PH_ID: begin
        id_q = b;
        add_to_sums(b);
        phase_q = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_q = {8'd0, b};
        add_to_sums(b);
        phase_q = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_q = length_q | {b, 8'd0};
        add_to_sums(b);
        position_q = '0;
        if (length_q > limit_q) begin
          phase_q = PH_SYNC1;
        end else if (length_q != 16'd0) begin
          phase_q = PH_PAYLOAD;
        end else begin
          phase_q = PH_CHECK_A;
        end
      end
      PH_PAYLOAD: begin
        word.payload_valid = 1'b1;
        word.payload_index = position_q;
        word.payload_byte  = b;
        add_to_sums(b);
        position_q = position_q + 16'd1;
        if (position_q >= length_q) phase_q = PH_CHECK_A;
      end
      PH_CHECK_A: begin
        phase_q = (b == sum_a) ? PH_CHECK_B : PH_SYNC1;
      end
      PH_CHECK_B: begin
        phase_q = PH_SYNC1;
        word.frame_ok = (b == sum_b);
      end
      default: begin
        phase_q = (b == sync1_q) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
    word.msg_class      = class_q;
    word.msg_id         = id_q;
    word.payload_length = length_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t next_word;
    if (!rst_ni) begin
      sync1_q    = SyncFirstReset;
      sync2_q    = SyncSecondReset;
      limit_q    = PayloadLimitReset;
      phase_q    = PH_SYNC1;
      sum_a      = '0;
      sum_b      = '0;
      class_q    = '0;
      id_q       = '0;
      length_q   = '0;
      position_q = '0;
      mismatches = 0;
      expected_words.delete();
      pending    = 0;
    end else begin
      // Retire the older word first: a new byte can be taken on the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          note_mismatch("result word with nothing expected", '0, '0);
        end else begin
          want = expected_words.pop_front();
          if (result_i.frame_ok !== want.frame_ok)
            note_mismatch("frame_ok", 16'(want.frame_ok), 16'(result_i.frame_ok));
          if (result_i.msg_class !== want.msg_class)
            note_mismatch("msg_class", 16'(want.msg_class), 16'(result_i.msg_class));
          if (result_i.msg_id !== want.msg_id)
            note_mismatch("msg_id", 16'(want.msg_id), 16'(result_i.msg_id));
          if (result_i.payload_length !== want.payload_length)
            note_mismatch("payload_length", want.payload_length, result_i.payload_length);
          if (result_i.payload_valid !== want.payload_valid)
            note_mismatch("payload_valid", 16'(want.payload_valid),
                          16'(result_i.payload_valid));
          if (result_i.payload_index !== want.payload_index)
            note_mismatch("payload_index", want.payload_index, result_i.payload_index);
          if (result_i.payload_byte !== want.payload_byte)
            note_mismatch("payload_byte", 16'(want.payload_byte), 16'(result_i.payload_byte));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SYNC_FIRST:    sync1_q = cfg_data_i[7:0];
          REG_SYNC_SECOND:   sync2_q = cfg_data_i[7:0];
          REG_PAYLOAD_LIMIT: limit_q = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        parse_byte(rx_byte_i, next_word);
        expected_words.push_back(next_word);
      end
      pending = expected_words.size();
    end
  end

endmodule

@@ verif/gnss_binary_frame_parser_unit_tb.sv @@
// Testbench top for gnss_binary_frame_parser_unit: drives frames, broken frames
// and noise bytes under several register settings; gbfp_checker does the checking.
// Depends on gbfp_pkg, gbfp_checker and the parser RTL.
module gnss_binary_frame_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gbfp_pkg::*;

  localparam logic [CfgIdxWidth-1:0] RegUnused = 2'd3;
  localparam int WatchdogLimit = 3000;

  typedef enum int {
    FLAW_NONE,
    FLAW_SYNC,
    FLAW_LENGTH,
    FLAW_CHECK_A,
    FLAW_CHECK_B
  } flaw_e;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_idx_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [7:0]              rx_byte_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  result_t                 result;
  int                      errors;
  int                      pending;

  logic [7:0]  sync1_val;
  logic [7:0]  sync2_val;
  logic [15:0] limit_val;
  logic [7:0]  frame_sum_a;
  logic [7:0]  frame_sum_b;
  logic        sender_gaps;
  logic        receiver_gaps;
  int          bytes_sent;
  int          ready_left;
  int          idle_cycles;

  gnss_binary_frame_parser_unit uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .frame_ok_o       (result.frame_ok),
    .msg_class_o      (result.msg_class),
    .msg_id_o         (result.msg_id),
    .payload_length_o (result.payload_length),
    .payload_valid_o  (result.payload_valid),
    .payload_index_o  (result.payload_index),
    .payload_byte_o   (result.payload_byte)
  );

  gbfp_checker frame_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_i    (result),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: alternate ready runs and stall bursts, or stay ready when told to.
  always @(posedge clk_i) begin
    if (!receiver_gaps) begin
      out_ready_i <= 1'b1;
    end else if (ready_left == 0) begin
      if (out_ready_i) begin
        out_ready_i <= 1'b0;
        ready_left = $urandom_range(1, 16);
      end else begin
        out_ready_i <= 1'b1;
        ready_left = $urandom_range(1, 40);
      end
    end else begin
      ready_left--;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Offer one word, maybe after an idle burst; leave valid high on return.
  task automatic push_byte(input logic [7:0] b);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic push_summed(input logic [7:0] b);
    frame_sum_a = frame_sum_a + b;
    frame_sum_b = frame_sum_b + frame_sum_a;
    push_byte(b);
  endtask

  // Hold the stream until every result word has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input logic [15:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_SYNC_FIRST:    sync1_val = data[7:0];
      REG_SYNC_SECOND:   sync2_val = data[7:0];
      REG_PAYLOAD_LIMIT: limit_val = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input logic [15:0] len, input flaw_e flaw);
    logic [7:0]  b;
    logic [15:0] frame_len;
    frame_len = len;
    push_byte(sync1_val);
    if (flaw == FLAW_SYNC) begin
      if ($urandom_range(0, 1) == 0 && sync1_val != sync2_val) begin
        b = sync1_val;
      end else begin
        b = sync2_val + 8'($urandom_range(1, 255));
      end
      push_byte(b);
      return;
    end
    push_byte(sync2_val);
    frame_sum_a = '0;
    frame_sum_b = '0;
    if (flaw == FLAW_LENGTH) begin
      frame_len = limit_val + 16'd1 + 16'($urandom_range(0, 65534 - int'(limit_val)));
    end
    push_summed(8'($urandom_range(0, 255)));
    push_summed(8'($urandom_range(0, 255)));
    push_summed(frame_len[7:0]);
    push_summed(frame_len[15:8]);
    if (flaw == FLAW_LENGTH) return;
    for (int i = 0; i < int'(frame_len); i++) begin
      push_summed(8'($urandom_range(0, 255)));
    end
    if (flaw == FLAW_CHECK_A) begin
      push_byte(frame_sum_a + 8'($urandom_range(1, 255)));
      return;
    end
    push_byte(frame_sum_a);
    if (flaw == FLAW_CHECK_B) begin
      push_byte(frame_sum_b ^ 8'($urandom_range(1, 255)));
    end else begin
      push_byte(frame_sum_b);
    end
  endtask

  // Mostly well-formed frames with random content, plus broken frames and noise.
  task automatic run_random(input int target);
    int          pick;
    int          max_len;
    logic [15:0] len;
    flaw_e       flaw;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 22) begin
        repeat ($urandom_range(1, 6)) begin
          push_byte(($urandom_range(0, 3) == 0) ? sync1_val : 8'($urandom_range(0, 255)));
        end
      end else if (pick < 25) begin
        // drain only while idling is allowed
        if (sender_gaps) wait_idle();
      end else begin
        max_len = (limit_val < 16'd12) ? int'(limit_val) : 12;
        len = 16'($urandom_range(0, max_len));
        if ($urandom_range(0, 19) == 0 && limit_val <= 16'd40) len = limit_val;
        case ($urandom_range(0, 9))
          6:       flaw = FLAW_SYNC;
          7:       flaw = (limit_val == 16'hFFFF) ? FLAW_NONE : FLAW_LENGTH;
          8:       flaw = FLAW_CHECK_A;
          9:       flaw = FLAW_CHECK_B;
          default: flaw = FLAW_NONE;
        endcase
        send_frame(len, flaw);
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    rx_byte_i     = '0;
    out_ready_i   = 1'b0;
    sender_gaps   = 1'b1;
    receiver_gaps = 1'b1;
    ready_left    = 0;
    idle_cycles   = 0;
    bytes_sent    = 0;
    sync1_val     = SyncFirstReset;
    sync2_val     = SyncSecondReset;
    limit_val     = PayloadLimitReset;
    frame_sum_a   = '0;
    frame_sum_b   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, good frames, a frame broken at each check byte and one too long.
    push_byte(8'h00);
    push_byte(8'hFF);
    send_frame(16'd0, FLAW_NONE);
    send_frame(16'd2, FLAW_NONE);
    // Repeated first sync byte is not taken as a restart.
    push_byte(sync1_val);
    push_byte(sync1_val);
    push_byte(sync2_val);
    send_frame(16'd1, FLAW_CHECK_A);
    send_frame(16'd0, FLAW_CHECK_B);
    send_frame(16'd0, FLAW_LENGTH);
    run_random(140);

    wait_idle();
    write_reg(REG_SYNC_FIRST, 16'h0000);
    write_reg(REG_SYNC_SECOND, 16'h00FF);
    write_reg(REG_PAYLOAD_LIMIT, 16'h0000);
    write_reg(RegUnused, 16'hFFFF);
    send_frame(16'd0, FLAW_NONE);
    run_random(230);

    wait_idle();
    write_reg(REG_SYNC_FIRST, 16'h00FF);
    write_reg(REG_SYNC_SECOND, 16'h0000);
    write_reg(REG_PAYLOAD_LIMIT, 16'hFFFF);
    run_random(330);

    wait_idle();
    write_reg(REG_SYNC_FIRST, 16'($urandom_range(0, 255)));
    write_reg(REG_SYNC_SECOND, 16'($urandom_range(0, 255)));
    write_reg(REG_PAYLOAD_LIMIT, 16'd3);
    send_frame(16'd3, FLAW_NONE);
    run_random(420);

    // Closing stretch: random setting, no idling on either side.
    wait_idle();
    write_reg(REG_SYNC_FIRST, 16'($urandom_range(0, 255)));
    write_reg(REG_SYNC_SECOND, 16'($urandom_range(0, 255)));
    write_reg(REG_PAYLOAD_LIMIT, 16'($urandom_range(1, 40)));
    sender_gaps   = 1'b0;
    receiver_gaps = 1'b0;
    run_random(500);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
